FILE: rtl/core/clipped_line_rasterizer_macros.svh
// assertion helpers used by the rasterizer top level
`ifndef CLIPPED_LINE_RASTERIZER_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_MACROS_SVH

// implication checked on every rising edge outside reset
`define CLR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clipped_line_rasterizer assertion failed");

// condition that must never be seen outside reset
`define CLR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("clipped_line_rasterizer assertion failed");

`endif

FILE: rtl/core/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Types and constants shared by the clipped line rasterizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

  localparam int COORD_W    = 12;
  localparam int TWICE_W    = 13;
  localparam int ERR_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int Q_DEPTH    = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_RIGHT  = 2'd1,
    CFG_CLIP_TOP    = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        pixel_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pix_x;
    logic signed [COORD_W-1:0] pix_y;
    logic [COLOR_W-1:0]        pix_color;
    logic                      write_enable;
    logic                      last;
    logic                      busy_res;
  } out_item_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [1:0]         step_x;
    logic signed [1:0]         step_y;
    logic [TWICE_W-1:0]        twice_dx;
    logic [TWICE_W-1:0]        twice_dy;
    logic signed [ERR_W-1:0]   error_init;
    logic                      x_major;
    logic [COLOR_W-1:0]        color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/clr_queue.sv
// ----------------------------------------------------------------------------
// clr_queue
// Short command queue between the decode front and the drawing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_queue
  import clr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire cmd_t      push_cmd,
  input  wire logic      pop,
  output cmd_t           head_cmd,
  output q_status_t      status
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clr_front.sv
// ----------------------------------------------------------------------------
// clr_front
// Accepts input beats and works out the line setup: deltas, step signs,
// major axis and the starting error term.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_front
  import clr_pkg::*;
(
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire q_status_t q_status,
  output logic           q_push,
  output cmd_t           q_cmd
);

  logic signed [COORD_W:0]  dx, dy;
  logic [COORD_W-1:0]       abs_dx, abs_dy;
  logic                     x_major;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    dx     = (COORD_W+1)'(in_data.end_x) - (COORD_W+1)'(in_data.start_x);
    dy     = (COORD_W+1)'(in_data.end_y) - (COORD_W+1)'(in_data.start_y);
    abs_dx = COORD_W'(dx[COORD_W] ? -dx : dx);
    abs_dy = COORD_W'(dy[COORD_W] ? -dy : dy);
    x_major = abs_dx > abs_dy;

    q_cmd.op       = in_data.op;
    q_cmd.start_x  = in_data.start_x;
    q_cmd.start_y  = in_data.start_y;
    q_cmd.end_x    = in_data.end_x;
    q_cmd.end_y    = in_data.end_y;
    q_cmd.color    = in_data.pixel_color;
    q_cmd.x_major  = x_major;
    q_cmd.twice_dx = {abs_dx, 1'b0};
    q_cmd.twice_dy = {abs_dy, 1'b0};
    q_cmd.step_x   = (dx == '0) ? 2'sd0 : (dx[COORD_W] ? -2'sd1 : 2'sd1);
    q_cmd.step_y   = (dy == '0) ? 2'sd0 : (dy[COORD_W] ? -2'sd1 : 2'sd1);
    // 2*minor - major
    if (x_major) begin
      q_cmd.error_init = $signed(ERR_W'({abs_dy, 1'b0})) - $signed(ERR_W'(abs_dx));
    end else begin
      q_cmd.error_init = $signed(ERR_W'({abs_dx, 1'b0})) - $signed(ERR_W'(abs_dy));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clr_back.sv
// ----------------------------------------------------------------------------
// clr_back
// Drawing back end: holds the walk state and clip registers, executes one
// command per cycle while output is free, keeping the result in its register.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_back
  import clr_pkg::*;
#(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire cmd_t                  q_cmd,
  input  wire q_status_t             q_status,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  localparam int CW_X   = $clog2(FB_WIDTH + 1);
  localparam int CW_Y   = $clog2(FB_HEIGHT + 1);
  localparam int CLIP_W = (CW_X > CW_Y) ? CW_X : CW_Y;

  logic [CLIP_W-1:0] clip_left_r, clip_right_r, clip_top_r, clip_bottom_r;
  logic [CLIP_W-1:0] cfg_w_sat, cfg_h_sat;

  logic signed [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_W-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic signed [1:0]         stp_x_r, stp_x_nxt, stp_y_r, stp_y_nxt;
  logic [TWICE_W-1:0]        tdx_r, tdx_nxt, tdy_r, tdy_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt, err_adj;
  logic                      xmaj_r, xmaj_nxt, active_r, active_nxt;
  logic [COLOR_W-1:0]        color_r, color_nxt;

  logic                      out_valid_r;
  out_item_t                 out_data_r, out_data_nxt;
  logic                      last, drawing, in_clip, err_ge;
  logic signed [COORD_W:0]   px, py;

  assign q_pop     = !q_status.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clip writes saturate at the framebuffer size
  assign cfg_w_sat = (int'(cfg_wdata) > FB_WIDTH)  ? CLIP_W'(FB_WIDTH)  : CLIP_W'(cfg_wdata);
  assign cfg_h_sat = (int'(cfg_wdata) > FB_HEIGHT) ? CLIP_W'(FB_HEIGHT) : CLIP_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_right_r  <= CLIP_W'(FB_WIDTH);
      clip_top_r    <= '0;
      clip_bottom_r <= CLIP_W'(FB_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLIP_LEFT:   clip_left_r   <= cfg_w_sat;
        CFG_CLIP_RIGHT:  clip_right_r  <= cfg_w_sat;
        CFG_CLIP_TOP:    clip_top_r    <= cfg_h_sat;
        CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_h_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    stp_x_nxt  = stp_x_r;
    stp_y_nxt  = stp_y_r;
    tdx_nxt    = tdx_r;
    tdy_nxt    = tdy_r;
    err_nxt    = err_r;
    xmaj_nxt   = xmaj_r;
    active_nxt = active_r;
    color_nxt  = color_r;
    err_ge     = !err_r[ERR_W-1];
    err_adj    = err_r;
    drawing    = 1'b1;

    if (q_cmd.op == OP_LOAD) begin
      cur_x_nxt = q_cmd.start_x;
      cur_y_nxt = q_cmd.start_y;
      tgt_x_nxt = q_cmd.end_x;
      tgt_y_nxt = q_cmd.end_y;
      stp_x_nxt = q_cmd.step_x;
      stp_y_nxt = q_cmd.step_y;
      tdx_nxt   = q_cmd.twice_dx;
      tdy_nxt   = q_cmd.twice_dy;
      err_nxt   = q_cmd.error_init;
      xmaj_nxt  = q_cmd.x_major;
      color_nxt = q_cmd.color;
    end else if (active_r) begin
      if (xmaj_r) begin
        cur_x_nxt = cur_x_r + COORD_W'(stp_x_r);
        if (err_ge) begin
          cur_y_nxt = cur_y_r + COORD_W'(stp_y_r);
          err_adj   = err_r - $signed(ERR_W'(tdx_r));
        end
        err_nxt = err_adj + $signed(ERR_W'(tdy_r));
      end else begin
        if (err_ge) begin
          cur_x_nxt = cur_x_r + COORD_W'(stp_x_r);
          err_adj   = err_r - $signed(ERR_W'(tdy_r));
        end
        cur_y_nxt = cur_y_r + COORD_W'(stp_y_r);
        err_nxt   = err_adj + $signed(ERR_W'(tdx_r));
      end
    end else begin
      // step with no line: repeat the position, nothing written
      drawing = 1'b0;
    end

    last = drawing && (xmaj_nxt ? (cur_x_nxt == tgt_x_nxt) : (cur_y_nxt == tgt_y_nxt));
    if (drawing) begin
      active_nxt = !last;
    end

    px = (COORD_W+1)'(cur_x_nxt);
    py = (COORD_W+1)'(cur_y_nxt);
    in_clip = (px >= $signed({1'b0, COORD_W'(clip_left_r)}))  &&
              (px <  $signed({1'b0, COORD_W'(clip_right_r)})) &&
              (py >= $signed({1'b0, COORD_W'(clip_top_r)}))   &&
              (py <  $signed({1'b0, COORD_W'(clip_bottom_r)}));

    out_data_nxt.pix_x        = cur_x_nxt;
    out_data_nxt.pix_y        = cur_y_nxt;
    out_data_nxt.pix_color    = color_nxt;
    out_data_nxt.write_enable = drawing && in_clip;
    out_data_nxt.last         = last;
    out_data_nxt.busy_res     = drawing && !last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      stp_x_r     <= '0;
      stp_y_r     <= '0;
      tdx_r       <= '0;
      tdy_r       <= '0;
      err_r       <= '0;
      xmaj_r      <= 1'b0;
      active_r    <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_x_r  <= cur_x_nxt;
        cur_y_r  <= cur_y_nxt;
        tgt_x_r  <= tgt_x_nxt;
        tgt_y_r  <= tgt_y_nxt;
        stp_x_r  <= stp_x_nxt;
        stp_y_r  <= stp_y_nxt;
        tdx_r    <= tdx_nxt;
        tdy_r    <= tdy_nxt;
        err_r    <= err_nxt;
        xmaj_r   <= xmaj_nxt;
        active_r <= active_nxt;
        color_r  <= color_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clipped_line_rasterizer.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line rasterizer with a clip rectangle, one pixel per beat.
// ----------------------------------------------------------------------------
// A load beat (op 0) sets up a line and returns its first pixel; each step
// beat (op 1) returns the next one, with write_enable set only inside the
// clip rectangle and last/busy_res marking the end of the line. Every input
// beat gives exactly one result beat. Sustained rate is one beat per clock in
// and out while out_ready holds: the front decodes a beat in the cycle it is
// accepted and pushes it into a two-entry command queue, and the back end
// retires one command per cycle into its output register when that is free,
// so a beat is held in the queue, then in the output register. Clip registers
// are written through cfg_* while the block is idle, a user rule the block
// does not enforce; values beyond the framebuffer are saturated to its size.
`default_nettype none

module clipped_line_rasterizer
  import clr_pkg::*;
#(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "clipped_line_rasterizer_macros.svh"

  q_status_t q_status;
  logic      q_push, q_pop;
  cmd_t      push_cmd, head_cmd;

  clr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  clr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  clr_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_cmd     (head_cmd),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a stalled result must not be overwritten by the next command
  `CLR_ASSERT_IMPL(a_pop_only_when_free, q_pop, !out_valid || out_ready)
  // the final pixel never reports more pixels pending
  `CLR_ASSERT_IMPL(a_last_not_busy, out_valid && out_data.last, !out_data.busy_res)
  // queue bookkeeping stays consistent
  `CLR_ASSERT_NEVER(a_queue_status, q_status.full && q_status.empty)

endmodule

`default_nettype wire
